@@ hdl/idfs_pkg.sv @@
// Shared widths and codes for the iterative depth-first traversal block.
`default_nettype none
package idfs_pkg;

  localparam int ID_W     = 6;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd2;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_VISIT = 1'b1;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_DIRECTED   = 1'b1;

endpackage
`default_nettype wire

@@ hdl/idfs_req_if.sv @@
// Request and response channel interfaces of the traversal block.
`default_nettype none
interface idfs_req_if import idfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   edge_from;
  logic [ID_W-1:0]   edge_to;
  modport src (output valid, func, edge_from, edge_to, input ready);
  modport snk (input valid, func, edge_from, edge_to, output ready);
endinterface

interface idfs_rsp_if import idfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     visit_node;
  logic [ID_W-1:0]     parent_node;
  logic                last;
  modport src (output valid, kind, status, visit_node, parent_node, last, input ready);
  modport snk (input valid, kind, status, visit_node, parent_node, last, output ready);
endinterface
`default_nettype wire

@@ hdl/idfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module idfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/iterative_dfs_traversal.sv @@
// Top level of the iterative depth-first traversal block over adjacency lists.
// An edge load appends one stored edge when directed and two when undirected, then hands the
// acknowledge transaction to the output register; rejected loads and other commands go straight to the acknowledge.
// A run clears the seen marks, tries each root, starts a tree at each unseen root, then pops and emits
// each visited node and scans each of its stored edges; a stalled output stretches any of these.
// One transaction at a time; synchronous reset empties the edge store and sets defaults.
`default_nettype none
module iterative_dfs_traversal import idfs_pkg::*; #(
  parameter int NODES      = 64,
  parameter int EDGE_SLOTS = 256
) (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            cfg_we,
  input wire logic            cfg_index,
  input wire logic [ID_W-1:0] cfg_data,
  idfs_req_if.snk             req,
  idfs_rsp_if.src             rsp
);

  localparam int NW = $clog2(NODES);
  localparam int EW = $clog2(EDGE_SLOTS);
  localparam int UW = $clog2(EDGE_SLOTS + 1);

  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_APP_A     = 15'h0002,
    S_APP_B     = 15'h0004,
    S_ACK       = 15'h0008,
    S_CLR       = 15'h0010,
    S_ROOT      = 15'h0020,
    S_ROOT_D    = 15'h0040,
    S_POP       = 15'h0080,
    S_POP_D     = 15'h0100,
    S_EMIT      = 15'h0200,
    S_HEAD      = 15'h0400,
    S_EDGE      = 15'h0800,
    S_EDGE_D    = 15'h1000,
    S_SEEN      = 15'h2000,
    S_NEXT_ROOT = 15'h4000
  } state_t;

  state_t              state;
  logic [ID_W-1:0]     node_count;
  logic                directed;
  logic [UW-1:0]       edges_used;
  logic [NODES-1:0]    head_valid;
  logic [ID_W-1:0]     node_a, node_b;
  logic                second;
  logic [EW-1:0]       slot;
  logic [STATUS_W-1:0] ack_status;
  logic [ID_W-1:0]     root, cidx, cur_u, cur_p, cur_v, visits;
  logic [NW-1:0]       top;
  logic [EW-1:0]       edge_ptr;
  logic [EW:0]         nxt;
  logic                out_valid;

  logic [ID_W-1:0]     n_eff;
  logic                out_free;
  logic                bad_id, no_room;

  logic                hd_we, tl_we, ds_we, nx_we, sn_we, st_we;
  logic [NW-1:0]       hd_wa, hd_ra, tl_wa, tl_ra, sn_wa, sn_ra, st_wa, st_ra;
  logic [EW-1:0]       hd_wd, hd_rd, tl_wd, tl_rd, ds_wa, nx_wa, ed_ra;
  logic [ID_W-1:0]     ds_wd, ds_rd;
  logic [EW:0]         nx_wd, nx_rd;
  logic                sn_wd, sn_rd;
  logic [2*ID_W-1:0]   st_wd, st_rd;

  assign n_eff    = (int'(node_count) > NODES - 1) ? ID_W'(NODES - 1) : node_count;
  assign out_free = !out_valid || rsp.ready;
  assign bad_id   = (req.edge_from == '0) || (req.edge_from > n_eff) ||
                    (req.edge_to == '0) || (req.edge_to > n_eff);
  assign no_room  = (int'(edges_used) + (directed ? 1 : 2)) > EDGE_SLOTS;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;

  always_comb begin
    hd_we = 1'b0; hd_wa = NW'(node_a); hd_wd = slot; hd_ra = NW'(cur_u);
    tl_we = 1'b0; tl_wa = NW'(node_a); tl_wd = slot; tl_ra = NW'(node_a);
    ds_we = 1'b0; ds_wa = EW'(edges_used); ds_wd = node_b;
    nx_we = 1'b0; nx_wa = EW'(edges_used); nx_wd = '0; ed_ra = edge_ptr;
    sn_we = 1'b0; sn_wa = NW'(cidx); sn_wd = 1'b0; sn_ra = NW'(root);
    st_we = 1'b0; st_wa = top; st_wd = {cur_v, cur_u}; st_ra = top - NW'(1);
    unique case (state)
      S_APP_A: begin
        ds_we = 1'b1;
        nx_we = 1'b1;
      end
      S_APP_B: begin
        tl_we = 1'b1;
        if (head_valid[NW'(node_a)]) begin
          nx_we = 1'b1;
          nx_wa = tl_rd;
          nx_wd = {1'b1, slot};
        end else begin
          hd_we = 1'b1;
        end
      end
      S_CLR: sn_we = 1'b1;
      S_ROOT_D: begin
        sn_wa = NW'(root);
        sn_wd = 1'b1;
        sn_we = !sn_rd;
        st_wa = '0;
        st_wd = {root, ID_W'(0)};
        st_we = !sn_rd;
      end
      S_EDGE_D: sn_ra = NW'(ds_rd);
      S_SEEN: begin
        sn_wa = NW'(cur_v);
        sn_wd = 1'b1;
        sn_we = !sn_rd;
        st_we = !sn_rd;
      end
      default: ;
    endcase
  end

  idfs_ram #(.WIDTH(EW), .DEPTH(NODES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  idfs_ram #(.WIDTH(EW), .DEPTH(NODES)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  idfs_ram #(.WIDTH(ID_W), .DEPTH(EDGE_SLOTS)) u_dest (
    .clk, .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ed_ra), .rdata(ds_rd));
  idfs_ram #(.WIDTH(EW + 1), .DEPTH(EDGE_SLOTS)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(ed_ra), .rdata(nx_rd));
  idfs_ram #(.WIDTH(1), .DEPTH(NODES)) u_seen (
    .clk, .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
  idfs_ram #(.WIDTH(2 * ID_W), .DEPTH(NODES)) u_stack (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= ID_W'(1);
      directed   <= 1'b0;
      edges_used <= '0;
      head_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count <= cfg_data;
          CFG_DIRECTED:   directed <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            ack_status <= ST_OK;
            node_a     <= req.edge_from;
            node_b     <= req.edge_to;
            second     <= !directed;
            visits     <= '0;
            cidx       <= ID_W'(1);
            root       <= ID_W'(1);
            top        <= '0;
            state      <= S_ACK;
            case (req.func)
              FUNC_ADD: begin
                if (bad_id) begin
                  ack_status <= ST_BAD_NODE;
                end else if (no_room) begin
                  ack_status <= ST_FULL;
                end else begin
                  state <= S_APP_A;
                end
              end
              FUNC_RUN: begin
                if (n_eff != '0) begin
                  state <= S_CLR;
                end
              end
              FUNC_CLEAR: begin
                head_valid <= '0;
                edges_used <= '0;
              end
              default: ;
            endcase
          end
        end
        S_APP_A: begin
          slot       <= EW'(edges_used);
          edges_used <= edges_used + UW'(1);
          state      <= S_APP_B;
        end
        S_APP_B: begin
          head_valid[NW'(node_a)] <= 1'b1;
          if (second) begin
            second <= 1'b0;
            node_a <= node_b;
            node_b <= node_a;
            state  <= S_APP_A;
          end else begin
            state <= S_ACK;
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            rsp.kind        <= KIND_ACK;
            rsp.status      <= ack_status;
            rsp.visit_node  <= '0;
            rsp.parent_node <= '0;
            rsp.last        <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_CLR: begin
          cidx <= cidx + ID_W'(1);
          if (cidx == n_eff) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: state <= S_ROOT_D;
        S_ROOT_D: begin
          if (sn_rd) begin
            state <= S_NEXT_ROOT;
          end else begin
            top   <= NW'(1);
            state <= S_POP;
          end
        end
        S_POP: begin
          if (top == '0) begin
            state <= S_NEXT_ROOT;
          end else begin
            top   <= top - NW'(1);
            state <= S_POP_D;
          end
        end
        S_POP_D: begin
          {cur_u, cur_p} <= st_rd;
          state          <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            rsp.kind        <= KIND_VISIT;
            rsp.status      <= ST_OK;
            rsp.visit_node  <= cur_u;
            rsp.parent_node <= cur_p;
            rsp.last        <= (visits == n_eff - ID_W'(1));
            visits          <= visits + ID_W'(1);
            state           <= head_valid[NW'(cur_u)] ? S_HEAD : S_POP;
          end
        end
        S_HEAD: begin
          edge_ptr <= hd_rd;
          state    <= S_EDGE;
        end
        S_EDGE: state <= S_EDGE_D;
        S_EDGE_D: begin
          nxt   <= nx_rd;
          cur_v <= ds_rd;
          if (ds_rd != '0 && ds_rd <= n_eff) begin
            state <= S_SEEN;
          end else if (nx_rd[EW]) begin
            edge_ptr <= nx_rd[EW-1:0];
            state    <= S_EDGE;
          end else begin
            state <= S_POP;
          end
        end
        S_SEEN: begin
          if (!sn_rd) begin
            top <= top + NW'(1);
          end
          if (nxt[EW]) begin
            edge_ptr <= nxt[EW-1:0];
            state    <= S_EDGE;
          end else begin
            state <= S_POP;
          end
        end
        S_NEXT_ROOT: begin
          if (root == n_eff) begin
            state <= S_IDLE;
          end else begin
            root  <= root + ID_W'(1);
            state <= S_ROOT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    int'(edges_used) <= EDGE_SLOTS)
    else $error("edge store count exceeds its capacity");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted twice in a row");
  a_visit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.kind == KIND_VISIT |-> rsp.status == ST_OK && rsp.visit_node != '0)
    else $error("visit record with bad status or node");

endmodule
`default_nettype wire
